>>> rtl/core/dbc_pkg.sv
// Package for the directory block cache: types, sizes and helper functions.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps

package dbc_pkg;

  // Number of built slots and the widths that follow from it.
  localparam int SLOTS  = 8;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // Field widths fixed by the interface.
  localparam int OFF_W    = 64;
  localparam int SIZE_W   = 20;
  localparam int MODE_W   = 2;
  localparam int SLOTF_W  = 3;
  localparam int ACTIVE_W = 4;

  // Reset value of the active slot count register.
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd6;

  // Depth of the two small queues.
  localparam int Q_DEPTH = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_e;

  // Command classes handed from the front to the back.
  typedef enum logic [2:0] {
    CMD_LOOKUP,
    CMD_INSERT_ZERO,
    CMD_INSERT,
    CMD_FLUSH,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [OFF_W-1:0]  start_offset;
    logic [SIZE_W-1:0] room;
    logic [OFF_W-1:0]  next_offset;
    logic              at_end;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [SLOTF_W-1:0] slot;
    logic [SIZE_W-1:0]  cached_size;
    logic [OFF_W-1:0]   cached_next_offset;
    logic               cached_at_end;
    logic               replaced;
  } rsp_t;

  typedef struct packed {
    cmd_kind_e kind;
    req_t      req;
  } cmd_t;

  // Clamp the programmed count into 1..SLOTS.
  function automatic logic [CNT_W-1:0] used_slots(input logic [ACTIVE_W-1:0] active);
    int v;
    v = int'(active);
    if (v < 1) v = 1;
    if (v > SLOTS) v = SLOTS;
    return CNT_W'(v);
  endfunction

  // The slot field carries the low three bits of the slot number.
  function automatic logic [SLOTF_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+SLOTF_W-1:0] ext;
    ext = {{SLOTF_W{1'b0}}, idx};
    return ext[SLOTF_W-1:0];
  endfunction

endpackage

>>> rtl/core/dbc_cmd_queue.sv
// Front of the directory block cache: classifies each request and queues it.
// Depends on dbc_pkg for the request and command types.
`timescale 1ns / 1ps

module dbc_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dbc_pkg::req_t req_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output dbc_pkg::cmd_t cmd_o
);

  dbc_pkg::cmd_t       mem_q [dbc_pkg::Q_DEPTH];
  dbc_pkg::cmd_t       cmd_in;
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          count_q, count_d;
  logic                do_push, do_pop;

  // Decode the mode and spot the offset-zero insert, which has a fixed slot.
  always_comb begin
    cmd_in.req = req_i;
    case (dbc_pkg::mode_e'(req_i.mode))
      dbc_pkg::MODE_LOOKUP: begin
        cmd_in.kind = dbc_pkg::CMD_LOOKUP;
      end
      dbc_pkg::MODE_INSERT: begin
        cmd_in.kind = (req_i.start_offset == '0) ? dbc_pkg::CMD_INSERT_ZERO
                                                 : dbc_pkg::CMD_INSERT;
      end
      dbc_pkg::MODE_FLUSH: begin
        cmd_in.kind = dbc_pkg::CMD_FLUSH;
      end
      default: begin
        cmd_in.kind = dbc_pkg::CMD_NOP;
      end
    endcase
  end

  assign full_o  = (count_q == 2'(dbc_pkg::Q_DEPTH));
  assign valid_o = (count_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

>>> rtl/core/dbc_rsp_queue.sv
// Result queue of the directory block cache; parts the engine from the reader.
// Depends on dbc_pkg for the result type.
`timescale 1ns / 1ps

module dbc_rsp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dbc_pkg::rsp_t rsp_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output dbc_pkg::rsp_t rsp_o
);

  dbc_pkg::rsp_t mem_q [dbc_pkg::Q_DEPTH];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == 2'(dbc_pkg::Q_DEPTH));
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rsp_o   = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rsp_i;
    end
  end

endmodule

>>> rtl/core/dbc_engine.sv
// Back end of the directory block cache: the tag store and its slot scanner.
// Depends on dbc_pkg for command, result and size definitions.
`timescale 1ns / 1ps

module dbc_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dbc_pkg::CNT_W-1:0]   used_i,
  input  logic                        cmd_valid_i,
  input  dbc_pkg::cmd_t               cmd_i,
  output logic                        cmd_pop_o,
  input  logic                        rsp_full_i,
  output logic                        rsp_push_o,
  output dbc_pkg::rsp_t               rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WORK = 2'b10
  } state_e;

  state_e                      state_q, state_d;
  dbc_pkg::cmd_t               cmd_q, cmd_d;
  logic [dbc_pkg::SLOT_W-1:0]  idx_q, idx_d;
  logic [dbc_pkg::SLOT_W-1:0]  last_idx;

  // Tag store; only the valid marks are reset.
  logic [dbc_pkg::SLOTS-1:0]   valid_q, valid_d;
  logic [dbc_pkg::OFF_W-1:0]   start_q [dbc_pkg::SLOTS];
  logic [dbc_pkg::OFF_W-1:0]   next_q  [dbc_pkg::SLOTS];
  logic [dbc_pkg::SIZE_W-1:0]  size_q  [dbc_pkg::SLOTS];
  logic                        eof_q   [dbc_pkg::SLOTS];

  logic                        wr_en;
  logic [dbc_pkg::SLOT_W-1:0]  wr_idx;
  logic                        match;

  assign last_idx = dbc_pkg::SLOT_W'(used_i - dbc_pkg::CNT_W'(1));

  // Lookup test against the slot under the scan pointer.
  assign match = valid_q[idx_q] && (start_q[idx_q] == cmd_q.req.start_offset)
                 && (cmd_q.req.room >= size_q[idx_q]);

  // Sequencer: load a command, then step one slot per cycle until decided; rsp_full_i holds it.
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    valid_d    = valid_q;
    cmd_pop_o  = 1'b0;
    rsp_push_o = 1'b0;
    rsp_o      = '0;
    wr_en      = 1'b0;
    wr_idx     = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = (cmd_i.kind == dbc_pkg::CMD_INSERT) ? dbc_pkg::SLOT_W'(1) : '0;
          state_d   = ST_WORK;
        end
      end
      ST_WORK: begin
        if (!rsp_full_i) begin
          case (cmd_q.kind)
            dbc_pkg::CMD_LOOKUP: begin
              if (match) begin
                rsp_push_o               = 1'b1;
                rsp_o.hit                = 1'b1;
                rsp_o.slot               = dbc_pkg::slot_field(idx_q);
                rsp_o.cached_size        = size_q[idx_q];
                rsp_o.cached_next_offset = next_q[idx_q];
                rsp_o.cached_at_end      = eof_q[idx_q];
              end else if (idx_q == last_idx) begin
                rsp_push_o = 1'b1;
              end else begin
                idx_d = idx_q + dbc_pkg::SLOT_W'(1);
              end
            end
            dbc_pkg::CMD_INSERT_ZERO: begin
              rsp_push_o     = 1'b1;
              rsp_o.replaced = valid_q[0];
              wr_en          = 1'b1;
            end
            dbc_pkg::CMD_INSERT: begin
              if (last_idx == '0) begin
                // A single active slot takes every insert.
                rsp_push_o     = 1'b1;
                rsp_o.replaced = valid_q[0];
                wr_en          = 1'b1;
              end else if (!valid_q[idx_q] || (idx_q == last_idx)) begin
                rsp_push_o     = 1'b1;
                rsp_o.slot     = dbc_pkg::slot_field(idx_q);
                rsp_o.replaced = valid_q[idx_q];
                wr_en          = 1'b1;
                wr_idx         = idx_q;
              end else begin
                idx_d = idx_q + dbc_pkg::SLOT_W'(1);
              end
            end
            dbc_pkg::CMD_FLUSH: begin
              rsp_push_o = 1'b1;
              valid_d    = '0;
            end
            default: begin
              rsp_push_o = 1'b1;
            end
          endcase
          if (wr_en) begin
            valid_d[wr_idx] = 1'b1;
          end
          if (rsp_push_o) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // Command register, scan pointer and slot payload carry no reset.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    if (wr_en) begin
      start_q[wr_idx] <= cmd_q.req.start_offset;
      next_q[wr_idx]  <= cmd_q.req.next_offset;
      size_q[wr_idx]  <= cmd_q.req.room;
      eof_q[wr_idx]   <= cmd_q.req.at_end;
    end
  end

endmodule

>>> rtl/core/directory_block_cache.sv
// Top level of the directory block cache: config register and the three parts.
// Depends on dbc_pkg, dbc_cmd_queue, dbc_engine and dbc_rsp_queue.
//
// Usage:
//   Requests enter through a queue interface: a transaction is taken at a
//   rising edge with push high and full low. Results leave the same way:
//   while empty is low the oldest result sits on rsp_o, and it is taken at
//   an edge with pop high. Every request gives exactly one result.
//   The active slot count is written through cfg_valid_i/cfg_ready_o; the
//   port is always ready and should only be written while the block is idle.
//   A request passes through the request queue, the engine and the result
//   queue. A lookup steps one slot per cycle, while the result queue has
//   room, until a hit or the last active slot; an insert from slot 1 on
//   until the first free slot or the last active slot. The single slot
//   scanner in the engine finishes one request before it takes the next.
//   Reset clears every valid mark and sets the active count to 6; no
//   clearing pass is needed. When the reader stalls, results pile up in a
//   two-entry queue, then the engine holds, and then the two-entry request
//   queue fills and raises full.
`timescale 1ns / 1ps

module directory_block_cache (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  input  dbc_pkg::req_t                   req_i,
  output logic                            full,
  output logic                            empty,
  input  logic                            pop,
  output dbc_pkg::rsp_t                   rsp_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dbc_pkg::ACTIVE_W-1:0]    cfg_data_i
);

  logic [dbc_pkg::ACTIVE_W-1:0] active_q, active_d;
  logic [dbc_pkg::CNT_W-1:0]    used;
  logic                         cmd_valid, cmd_pop;
  dbc_pkg::cmd_t                cmd;
  logic                         rsp_full, rsp_push;
  dbc_pkg::rsp_t                rsp_eng;

  // Configuration register.
  assign cfg_ready_o = 1'b1;
  assign active_d    = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : active_q;
  assign used        = dbc_pkg::used_slots(active_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= dbc_pkg::ACTIVE_RESET;
    end else begin
      active_q <= active_d;
    end
  end

  // Front: classify and queue requests.
  dbc_cmd_queue u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (req_i),
    .full_o  (full),
    .valid_o (cmd_valid),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd)
  );

  // Back: tag store and slot scanner.
  dbc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .used_i      (used),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_full_i  (rsp_full),
    .rsp_push_o  (rsp_push),
    .rsp_o       (rsp_eng)
  );

  // Result queue toward the reader.
  dbc_rsp_queue u_rsp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .rsp_i   (rsp_eng),
    .full_o  (rsp_full),
    .empty_o (empty),
    .pop_i   (pop),
    .rsp_o   (rsp_o)
  );

  // The engine never hands a result to a full result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rsp_push |-> !rsp_full)
    else $error("result pushed into a full queue");

  // A waiting result stays until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (!empty && !pop) |=> !empty)
    else $error("waiting result vanished without a pop");

  // A lookup hit never reports a replacement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (rsp_push && rsp_eng.hit) |-> !rsp_eng.replaced)
    else $error("hit result flagged as replaced");

  // A command is only taken from the front when one is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> cmd_valid)
    else $error("engine popped an empty command queue");

endmodule
